>>> rtl/wrlm_pkg.sv
package wrlm_pkg;

    // Ring geometry
    localparam int MAX_SAMPLES = 10;
    localparam int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    // Stream payload widths
    localparam int S_TDATA_W = 152;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USAGE_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAKE_DELAY_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SAMPLES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DENY_SAMPLES   = 3'd5;

    localparam logic [3:0] WINDOW_RESET = 4'd10;
    localparam logic [3:0] DENY_RESET   = 4'd1;

    // Action codes
    localparam logic [1:0] ACT_ACCOUNT = 2'd0;
    localparam logic [1:0] ACT_CHECK   = 2'd1;
    localparam logic [1:0] ACT_TICK    = 2'd2;

    // Result classes
    localparam logic [1:0] CLS_ANSWERED = 2'd0;
    localparam logic [1:0] CLS_FAKE     = 2'd1;

    // Penalty modes
    localparam logic [1:0] PEN_NONE  = 2'd0;
    localparam logic [1:0] PEN_FAKE  = 2'd1;
    localparam logic [1:0] PEN_BAN   = 2'd2;
    localparam logic [1:0] PEN_DELAY = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DECIDE,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic scan_step;
        logic decide;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic ban;
        logic sample_nz;
        logic scan_last;
    } sts_t;

    // Clamp the window register to 1..MAX_SAMPLES
    function automatic logic [CNT_W-1:0] window_in_use(input logic [3:0] w);
        logic [31:0] n;
        n = {28'd0, w};
        if (n == 32'd0) n = 32'd1;
        if (n > 32'(MAX_SAMPLES)) n = 32'(MAX_SAMPLES);
        return n[CNT_W-1:0];
    endfunction

endpackage

>>> rtl/wrlm_ctrl.sv
module wrlm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    input  wrlm_pkg::sts_t sts,
    output wrlm_pkg::cmd_t cmd
);

    wrlm_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wrlm_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid) state_next = wrlm_pkg::ST_EXEC;
            end
            wrlm_pkg::ST_EXEC:
            begin
                if (sts.is_tick && sts.sample_nz && !sts.ban)
                    state_next = wrlm_pkg::ST_SCAN;
                else
                    state_next = wrlm_pkg::ST_DELIVER;
            end
            wrlm_pkg::ST_SCAN:
            begin
                if (sts.scan_last) state_next = wrlm_pkg::ST_DECIDE;
            end
            wrlm_pkg::ST_DECIDE:
            begin
                state_next = wrlm_pkg::ST_DELIVER;
            end
            wrlm_pkg::ST_DELIVER:
            begin
                if (out_free) state_next = wrlm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = wrlm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            wrlm_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.load_in   = s_axis_tvalid;
            end
            wrlm_pkg::ST_EXEC:    cmd.exec      = 1'b1;
            wrlm_pkg::ST_SCAN:    cmd.scan_step = 1'b1;
            wrlm_pkg::ST_DECIDE:  cmd.decide    = 1'b1;
            wrlm_pkg::ST_DELIVER: cmd.load_out  = out_free;
            default:              cmd           = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    assign m_axis_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wrlm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/wrlm_dp.sv
module wrlm_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wrlm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wrlm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [wrlm_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    input  logic [wrlm_pkg::S_TUSER_W-1:0]      s_axis_tuser,
    output logic [wrlm_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  wrlm_pkg::cmd_t                      cmd,
    output wrlm_pkg::sts_t                      sts
);

    localparam int IDX_W = wrlm_pkg::IDX_W;
    localparam int CNT_W = wrlm_pkg::CNT_W;

    // Configuration registers
    logic        enable_reg;
    logic [31:0] limit_reg;
    logic [1:0]  penalty_reg;
    logic [15:0] delay_cfg_reg;
    logic [3:0]  window_reg;
    logic [3:0]  deny_cfg_reg;

    // Monitor state
    logic [31:0]      usage_reg, usage_next;
    logic [31:0]      ring_reg [wrlm_pkg::MAX_SAMPLES];
    logic [31:0]      ring_next [wrlm_pkg::MAX_SAMPLES];
    logic [IDX_W-1:0] ring_index_reg, ring_index_next;
    logic             deny_reg, deny_next;
    logic [63:0]      dig_hi_reg, dig_hi_next;
    logic [63:0]      dig_lo_reg, dig_lo_next;

    // Tick working registers
    logic [IDX_W-1:0] tick_idx_reg, tick_idx_next;
    logic [IDX_W-1:0] scan_j_reg, scan_j_next;
    logic [CNT_W-1:0] exceed_reg, exceed_next;

    // Latched input word
    logic [1:0]  in_action_reg;
    logic [1:0]  in_class_reg;
    logic [16:0] in_weight_reg;
    logic [63:0] in_hi_reg;
    logic [63:0] in_lo_reg;

    // Result and output registers
    logic        res_fake_reg, res_fake_next;
    logic [15:0] res_delay_reg, res_delay_next;
    logic [3:0]  res_exceed_reg, res_exceed_next;
    logic        out_denied_reg;
    logic        out_fake_reg;
    logic [15:0] out_delay_reg;
    logic [3:0]  out_exceed_reg;

    logic [CNT_W-1:0] win_n;
    logic [IDX_W-1:0] idx_fix;
    logic             active;
    logic [31:0]      amount;
    logic [32:0]      sum;
    logic [31:0]      sat_sum;
    logic             deny_new;
    logic [31:0]      exceed_wide;
    logic [3:0]       exceed_sat;

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] i,
                                                 input logic [CNT_W-1:0] n);
        if (CNT_W'(i) + CNT_W'(1) == n)
            return '0;
        else
            return i + IDX_W'(1);
    endfunction

    assign win_n   = wrlm_pkg::window_in_use(window_reg);
    assign idx_fix = (CNT_W'(ring_index_reg) >= win_n) ? '0 : ring_index_reg;
    assign active  = enable_reg && (limit_reg != 32'd0);

    assign amount  = (in_class_reg == wrlm_pkg::CLS_FAKE) ? 32'd1 : {15'd0, in_weight_reg};
    assign sum     = {1'b0, usage_reg} + {1'b0, amount};
    assign sat_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

    assign exceed_wide = 32'(exceed_reg);
    assign deny_new    = exceed_wide >= {28'd0, deny_cfg_reg};
    assign exceed_sat  = (exceed_wide > 32'd15) ? 4'd15 : exceed_wide[3:0];

    assign sts.is_tick   = (in_action_reg == wrlm_pkg::ACT_TICK);
    assign sts.ban       = (penalty_reg == wrlm_pkg::PEN_BAN);
    assign sts.sample_nz = (usage_reg != 32'd0);
    assign sts.scan_last = (CNT_W'(scan_j_reg) + CNT_W'(1) == win_n);

    always_comb
    begin
        usage_next      = usage_reg;
        ring_next       = ring_reg;
        ring_index_next = ring_index_reg;
        deny_next       = deny_reg;
        dig_hi_next     = dig_hi_reg;
        dig_lo_next     = dig_lo_reg;
        tick_idx_next   = tick_idx_reg;
        scan_j_next     = scan_j_reg;
        exceed_next     = exceed_reg;
        res_fake_next   = res_fake_reg;
        res_delay_next  = res_delay_reg;
        res_exceed_next = res_exceed_reg;

        if (cmd.exec)
        begin
            res_fake_next   = 1'b0;
            res_delay_next  = 16'd0;
            res_exceed_next = 4'd0;
            case (in_action_reg)
                wrlm_pkg::ACT_ACCOUNT:
                begin
                    if (active)
                    begin
                        if (in_class_reg == wrlm_pkg::CLS_FAKE)
                            usage_next = sat_sum;
                        else if (in_class_reg == wrlm_pkg::CLS_ANSWERED &&
                                 (in_hi_reg != dig_hi_reg || in_lo_reg != dig_lo_reg))
                        begin
                            usage_next  = sat_sum;
                            dig_hi_next = in_hi_reg;
                            dig_lo_next = in_lo_reg;
                        end
                    end
                end
                wrlm_pkg::ACT_CHECK:
                begin
                    if (active && deny_reg && penalty_reg != wrlm_pkg::PEN_NONE)
                    begin
                        res_fake_next  = (penalty_reg != wrlm_pkg::PEN_DELAY);
                        res_delay_next = delay_cfg_reg;
                    end
                end
                wrlm_pkg::ACT_TICK:
                begin
                    // Store the running count and clear it
                    ring_next[idx_fix] = usage_reg;
                    usage_next         = 32'd0;
                    tick_idx_next      = idx_fix;
                    ring_index_next    = idx_fix;
                    scan_j_next        = '0;
                    exceed_next        = '0;
                    if (usage_reg != 32'd0)
                    begin
                        if (penalty_reg == wrlm_pkg::PEN_BAN)
                            deny_next = 1'b1;
                    end
                    else if (deny_reg)
                        deny_next = 1'b0;
                    else
                        ring_index_next = advance(idx_fix, win_n);
                end
                default:
                begin
                    res_fake_next = 1'b0;
                end
            endcase
        end

        if (cmd.scan_step)
        begin
            if (ring_reg[scan_j_reg] > limit_reg)
                exceed_next = exceed_reg + CNT_W'(1);
            scan_j_next = scan_j_reg + IDX_W'(1);
        end

        if (cmd.decide)
        begin
            deny_next       = deny_new;
            res_exceed_next = exceed_sat;
            if (deny_new)
                ring_next[tick_idx_reg] = 32'd0;
            if (!deny_reg && !deny_new)
                ring_index_next = advance(tick_idx_reg, win_n);
            else
                ring_index_next = tick_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            limit_reg      <= 32'd0;
            penalty_reg    <= wrlm_pkg::PEN_NONE;
            delay_cfg_reg  <= 16'd0;
            window_reg     <= wrlm_pkg::WINDOW_RESET;
            deny_cfg_reg   <= wrlm_pkg::DENY_RESET;
            usage_reg      <= 32'd0;
            for (int k = 0; k < wrlm_pkg::MAX_SAMPLES; k++)
                ring_reg[k] <= 32'd0;
            ring_index_reg <= '0;
            deny_reg       <= 1'b0;
            dig_hi_reg     <= 64'd0;
            dig_lo_reg     <= 64'd0;
        end
        else
        begin
            usage_reg      <= usage_next;
            ring_reg       <= ring_next;
            ring_index_reg <= ring_index_next;
            deny_reg       <= deny_next;
            dig_hi_reg     <= dig_hi_next;
            dig_lo_reg     <= dig_lo_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    wrlm_pkg::CFG_ENABLE:         enable_reg    <= cfg_wdata[0];
                    wrlm_pkg::CFG_USAGE_LIMIT:    limit_reg     <= cfg_wdata;
                    wrlm_pkg::CFG_PENALTY_MODE:   penalty_reg   <= cfg_wdata[1:0];
                    wrlm_pkg::CFG_FAKE_DELAY_MS:  delay_cfg_reg <= cfg_wdata[15:0];
                    wrlm_pkg::CFG_WINDOW_SAMPLES: window_reg    <= cfg_wdata[3:0];
                    wrlm_pkg::CFG_DENY_SAMPLES:   deny_cfg_reg  <= cfg_wdata[3:0];
                    default:                      enable_reg    <= enable_reg;
                endcase
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        tick_idx_reg   <= tick_idx_next;
        scan_j_reg     <= scan_j_next;
        exceed_reg     <= exceed_next;
        res_fake_reg   <= res_fake_next;
        res_delay_reg  <= res_delay_next;
        res_exceed_reg <= res_exceed_next;
        if (cmd.load_in)
        begin
            in_action_reg <= s_axis_tuser[1:0];
            in_class_reg  <= s_axis_tdata[1:0];
            in_weight_reg <= s_axis_tdata[18:2];
            in_hi_reg     <= s_axis_tdata[82:19];
            in_lo_reg     <= s_axis_tdata[146:83];
        end
        if (cmd.load_out)
        begin
            out_denied_reg <= deny_reg;
            out_fake_reg   <= res_fake_reg;
            out_delay_reg  <= res_delay_reg;
            out_exceed_reg <= res_exceed_reg;
        end
    end

    assign m_axis_tdata = {2'b00, out_exceed_reg, out_delay_reg, out_fake_reg, out_denied_reg};

endmodule

>>> rtl/windowed_rate_limit_monitor_core.sv
// Channel  | Direction | Handshake                    | Payload (lowest bit up)
// ---------+-----------+------------------------------+-------------------------------------
// s_axis   | in        | s_axis_tvalid/s_axis_tready  | tuser: action; tdata: result_class,
//          |           |                              |   dw_weight, digest_high, digest_low
// m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata: denied, fake_answer,
//          |           |                              |   delay_ms, exceed_count
// cfg      | in        | cfg_we (no wait)             | cfg_index, cfg_wdata
//
// Account, check and unknown words, and ticks with a zero sample or in ban mode, go
// through accept, execute and deliver. Any other tick adds a scan and a decide step
// before deliver, over n ring entries, n the window in use (1..10): the scan reads one ring entry per cycle.
// Reset (rst_n, async) clears the usage count, ring, index, deny flag and digest, and sets config to its reset values.
// A result waiting on m_axis does not hold off the next word; only the deliver
// step waits for the output register to empty.
module windowed_rate_limit_monitor_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [wrlm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wrlm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Input words
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [1:0] result_class, [18:2] dw_weight, [82:19] digest_high,
    // [146:83] digest_low, rest zero
    input  logic [wrlm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  logic [wrlm_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // Result words
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] denied, [1] fake_answer, [17:2] delay_ms, [21:18] exceed_count, rest zero
    output logic [wrlm_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    wrlm_pkg::cmd_t cmd;
    wrlm_pkg::sts_t sts;

    // Sequence each word: latch, execute, scan and decide on nonzero non-ban ticks, deliver
    wrlm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    // Hold config, usage count, sample ring, deny flag and the result registers
    wrlm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tdata (m_axis_tdata),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
